>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, also checked through reset
`define ASSERT_ALW_NXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/pps_pkg.sv
`default_nettype none
package pps_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int XW   = 36;   // cordic x/y datapath, q20 with growth
  localparam int ZW   = 33;   // residual angle, 2^32 per turn
  localparam int RW   = 27;   // rotated offset, q12
  localparam int DIVB = 15;   // quotient bits, clamped to steer_limit at the output
  localparam int R2W  = 56;
  localparam int DW   = 71;   // remainder / shifted divisor width
  localparam int AW   = 4;

  localparam logic [16:0] INV_GAIN = 17'd39797;

  localparam logic [1:0] REG_GAIN     = 2'd0;
  localparam logic [1:0] REG_LIMIT    = 2'd1;
  localparam logic [1:0] REG_THROTTLE = 2'd2;

  localparam logic [15:0] GAIN_RST     = 16'd256;
  localparam logic [12:0] LIMIT_RST    = 13'd1638;
  localparam logic [12:0] THROTTLE_RST = 13'd819;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [DW-1:0]   rem;
    logic [R2W-1:0]  r2;
    logic [DIVB-1:0] q;
    logic            neg;
    logic            zero;
  } div_t;

  function automatic logic [ZW-1:0] atan_lut(input int i);
    logic [ZW-1:0] v;
    case (i)
      0:  v = 33'd536870912;
      1:  v = 33'd316933406;
      2:  v = 33'd167458907;
      3:  v = 33'd85004756;
      4:  v = 33'd42667331;
      5:  v = 33'd21354465;
      6:  v = 33'd10679838;
      7:  v = 33'd5340245;
      8:  v = 33'd2670163;
      9:  v = 33'd1335087;
      10: v = 33'd667544;
      11: v = 33'd333772;
      12: v = 33'd166886;
      13: v = 33'd83443;
      14: v = 33'd41722;
      15: v = 33'd20861;
      16: v = 33'd10430;
      17: v = 33'd5215;
      18: v = 33'd2608;
      19: v = 33'd1304;
      20: v = 33'd652;
      21: v = 33'd326;
      22: v = 33'd163;
      23: v = 33'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/pps_if.sv
`default_nettype none
interface pps_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] goal_x;
  logic signed [23:0] goal_y;
  logic signed [23:0] vehicle_x;
  logic signed [23:0] vehicle_y;
  logic [15:0]        heading;
  modport source(output valid, goal_x, goal_y, vehicle_x, vehicle_y, heading, input ready);
  modport sink(input valid, goal_x, goal_y, vehicle_x, vehicle_y, heading, output ready);
endinterface

interface pps_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] steer_angle;
  logic [12:0]        drive_level;
  logic               clamped;
  logic               goal_at_vehicle;
  modport source(output valid, steer_angle, drive_level, clamped, goal_at_vehicle, input ready);
  modport sink(input valid, steer_angle, drive_level, clamped, goal_at_vehicle, output ready);
endinterface
`default_nettype wire

>>> rtl/pps_cordic_cell.sv
`default_nettype none
module pps_cordic_cell import pps_pkg::*; #(
  parameter int STAGE = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire cordic_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cordic_t      out_data
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  cordic_t              data_next;

  always_comb begin
    xs = in_data.x >>> STAGE;
    ys = in_data.y >>> STAGE;
    if (!in_data.z[ZW-1]) begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - atan_lut(STAGE);
    end else begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + atan_lut(STAGE);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pps_div_cell.sv
`default_nettype none
module pps_div_cell import pps_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire div_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output div_t      out_data
);

  logic [DW-1:0] dvs;
  logic          ge;
  div_t          data_next;

  // one restoring step: quotient bit BIT
  always_comb begin
    dvs       = DW'(in_data.r2) << BIT;
    ge        = in_data.rem >= dvs;
    data_next = in_data;
    if (ge) begin
      data_next.rem = in_data.rem - dvs;
    end
    data_next.q[BIT] = ge;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pure_pursuit_steering.sv
// pure pursuit steering, fully pipelined
// cmd (sink): goal point, vehicle position and heading, one beat per query.
// res (source): steer_angle, drive_level, clamped, goal_at_vehicle, one beat
//   per query, in query order.
// apb port: steer_gain at 0x0, steer_limit at 0x4, throttle_level at 0x8;
//   write only while the pipe is empty, pready is tied high.
// path: cmd beat to res valid passes the input register, one cordic
//   cell per stage, three multiply stages, fifteen divide cells and the
//   output register.
// throughput: one query per cycle; every stage is a register with its own
//   valid bit, so a bubble anywhere lets cmd keep flowing.
// stall: when res is held, beats pile up stage by stage and cmd.ready falls
//   only once every stage is full.
// reset (rst, synchronous): all valid bits clear, registers return to
//   gain 1.0, limit 0.4 and throttle 0.2.
`default_nettype none
module pure_pursuit_steering import pps_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  pps_in_if.sink             cmd,
  pps_out_if.source          res,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [AW-1:0] paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] steer_gain;
  logic [12:0] steer_limit;
  logic [12:0] throttle_level;

  // config registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_gain     <= GAIN_RST;
      steer_limit    <= LIMIT_RST;
      throttle_level <= THROTTLE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_GAIN:     steer_gain     <= pwdata[15:0];
        REG_LIMIT:    steer_limit    <= pwdata[12:0];
        REG_THROTTLE: throttle_level <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GAIN:     prdata = 32'(steer_gain);
      REG_LIMIT:    prdata = 32'(steer_limit);
      REG_THROTTLE: prdata = 32'(throttle_level);
      default:      prdata = '0;
    endcase
  end

  // front: offset and quadrant fold
  logic            c_valid [0:CORDIC_STAGES];
  logic            c_ready [0:CORDIC_STAGES];
  cordic_t         c_data  [0:CORDIC_STAGES];
  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic [15:0]     ang;
  logic [15:0]     ang_adj;
  logic            flip;
  cordic_t         front_next;

  always_comb begin
    dx      = 25'(cmd.goal_x) - 25'(cmd.vehicle_x);
    dy      = 25'(cmd.goal_y) - 25'(cmd.vehicle_y);
    ang     = 16'd0 - cmd.heading;
    flip    = ang inside {[16'h4000:16'hBFFF]};
    ang_adj = flip ? ang + 16'h8000 : ang;
    front_next.x = XW'(dx) <<< 8;
    front_next.y = XW'(dy) <<< 8;
    if (flip) begin
      front_next.x = -front_next.x;
      front_next.y = -front_next.y;
    end
    front_next.z = ZW'(signed'(ang_adj)) <<< 16;
  end

  assign cmd.ready = !c_valid[0] || c_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (cmd.ready) begin
      c_valid[0] <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      c_data[0] <= front_next;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    pps_cordic_cell #(.STAGE(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[g]),
      .in_ready  (c_ready[g]),
      .in_data   (c_data[g]),
      .out_valid (c_valid[g+1]),
      .out_ready (c_ready[g+1]),
      .out_data  (c_data[g+1])
    );
  end

  // gain compensation
  logic                   m1_valid;
  logic                   m1_take;
  logic signed [XW+17:0]  px;
  logic signed [XW+17:0]  py;
  logic                   m2_valid;
  logic                   m2_take;
  logic                   d_take;
  logic signed [RW-1:0]   rx;
  logic signed [RW-1:0]   ry;
  logic signed [2*RW-1:0] sqx_c;
  logic signed [2*RW-1:0] sqy_c;
  logic [2*RW-1:0]        sqx;
  logic [2*RW-1:0]        sqy;
  logic [RW-1:0]          ay;
  logic                   m2_neg;
  logic                   m2_zero;

  logic  d_valid [0:DIVB];
  logic  d_ready [0:DIVB];
  div_t  d_data  [0:DIVB];
  logic [15+RW:0] num;

  assign c_ready[CORDIC_STAGES] = m1_take;
  assign m1_take = !m1_valid || m2_take;
  assign d_take  = !d_valid[0] || d_ready[0];
  assign m2_take = !m2_valid || d_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (m1_take) begin
      m1_valid <= c_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (m1_take && c_valid[CORDIC_STAGES]) begin
      px <= c_data[CORDIC_STAGES].x * signed'({1'b0, INV_GAIN});
      py <= c_data[CORDIC_STAGES].y * signed'({1'b0, INV_GAIN});
    end
  end

  // squares and magnitude
  always_comb begin
    rx    = RW'(px >>> 24);
    ry    = RW'(py >>> 24);
    sqx_c = rx * rx;
    sqy_c = ry * ry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (m2_take) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m2_take && m1_valid) begin
      sqx     <= sqx_c;
      sqy     <= sqy_c;
      ay      <= ry[RW-1] ? RW'(-ry) : RW'(ry);
      m2_neg  <= ry[RW-1];
      m2_zero <= (rx == '0) && (ry == '0);
    end
  end

  // r2 and numerator, first divide register
  assign num = steer_gain * ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (d_take) begin
      d_valid[0] <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_take && m2_valid) begin
      d_data[0].rem  <= DW'(num) << 17;
      d_data[0].r2   <= R2W'(sqx) + R2W'(sqy);
      d_data[0].q    <= '0;
      d_data[0].neg  <= m2_neg;
      d_data[0].zero <= m2_zero;
    end
  end

  for (genvar g = 0; g < DIVB; g++) begin : g_div
    pps_div_cell #(.BIT(DIVB - 1 - g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (d_valid[g]),
      .in_ready  (d_ready[g]),
      .in_data   (d_data[g]),
      .out_valid (d_valid[g+1]),
      .out_ready (d_ready[g+1]),
      .out_data  (d_data[g+1])
    );
  end

  // clamp and output register
  logic               o_take;
  logic               over;
  logic [12:0]        mag;
  logic signed [13:0] steer_c;

  assign o_take        = !res.valid || res.ready;
  assign d_ready[DIVB] = o_take;

  always_comb begin
    over    = d_data[DIVB].q > DIVB'(steer_limit);
    mag     = over ? steer_limit : d_data[DIVB].q[12:0];
    steer_c = d_data[DIVB].neg ? -signed'(14'(mag)) : signed'(14'(mag));
    if (d_data[DIVB].zero) begin
      steer_c = '0;
      over    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (o_take) begin
      res.valid <= d_valid[DIVB];
    end
  end

  always_ff @(posedge clk) begin
    if (o_take && d_valid[DIVB]) begin
      res.steer_angle     <= steer_c;
      res.drive_level     <= throttle_level;
      res.clamped         <= over;
      res.goal_at_vehicle <= d_data[DIVB].zero;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pps_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pps_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [13:0] steer_angle,
  input wire logic              clamped,
  input wire logic              goal_at_vehicle
);

  `ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(steer_angle))
  `ASSERT_IMP(a_goal_zero, clk, rst, out_valid && goal_at_vehicle, steer_angle == 14'sd0 && !clamped)
  `ASSERT_IMP(a_no_min, clk, rst, out_valid, steer_angle != -14'sd8192)
  `ASSERT_ALW_NXT(a_rst_empty, clk, rst, !out_valid)

endmodule

bind pure_pursuit_steering pps_checker u_pps_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (res.valid),
  .out_ready       (res.ready),
  .steer_angle     (res.steer_angle),
  .clamped         (res.clamped),
  .goal_at_vehicle (res.goal_at_vehicle)
);
`default_nettype wire
